@@ design/image_crc32_vector_verifier_assert.svh @@
// Assertion macros for the image verifier checker.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef IMAGE_CRC32_VECTOR_VERIFIER_ASSERT_SVH
`define IMAGE_CRC32_VECTOR_VERIFIER_ASSERT_SVH

// clocked check, switched off while reset is asserted
`define ICV_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("image verifier check failed");

// clocked check that also holds during reset
`define ICV_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("image verifier check failed");

`endif

@@ design/icv_pkg.sv @@
// Shared types, constants and the CRC byte step for the image verifier.
// No dependencies.
`timescale 1ns / 1ps

package icv_pkg;

	localparam int unsigned MAX_IMAGE_BYTES = 1048576;
	localparam int unsigned POS_W = $clog2(MAX_IMAGE_BYTES + 1);
	localparam int unsigned SIZE_W = 21;
	localparam int unsigned OFFSET_W = 20;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] RAM_BASE = 32'h2000_0000;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_IMAGE_BYTES);
	localparam logic [POS_W-1:0] VECTOR_BYTES = POS_W'(8);
	localparam logic [POS_W-1:0] FIELD_BYTES = POS_W'(4);

	localparam logic [ADDR_W-1:0] RST_SLOT_BASE = 32'h0800_0000;
	localparam logic [SIZE_W-1:0] RST_SLOT_SIZE = SIZE_W'(1048576);
	localparam logic [OFFSET_W-1:0] RST_CRC_OFFSET = '0;
	localparam logic [ADDR_W-1:0] RST_RAM_END = 32'h2000_1FFF;
	localparam logic [31:0] RST_EXPECTED_CRC = '0;

	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_BASE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_SIZE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CRC_OFFSET = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RAM_END = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_CRC = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_req_t;

	typedef struct packed {
		logic [31:0] crc_value;
		logic        crc_match;
		logic        vector_ok;
		logic        size_ok;
	} result_t;

	// reflected CRC-32, one byte, bit at a time
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ design/image_crc32_vector_verifier.sv @@
// Image CRC-32 and vector table verifier, top level.
// Depends on icv_pkg.
`timescale 1ns / 1ps

// Streams a firmware image one byte per request and, on the request marked
// last_byte, returns one result: the reflected CRC-32 of the image with the
// four-byte checksum field at crc_offset_q counted as zero, its match
// against expected_crc, the stack pointer and reset vector range checks, and
// the size check against the slot. One byte is taken every cycle unless
// byte_stall is high; a last byte goes through the input register, then the
// eight-bit CRC step and the checks, then the result register. The byte side
// stalls only when a last byte waits behind a result that is itself stalled.
// Configuration is written through wr_en, wr_index and wr_data; the user must
// write it only while no image is in flight, which the block does not
// enforce. Unknown indexes are ignored.
module image_crc32_vector_verifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [icv_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [icv_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic                                byte_valid,
	output logic                                byte_stall,
	input  icv_pkg::byte_req_t                  byte_req,
	output logic                                result_valid,
	input  logic                                result_stall,
	output icv_pkg::result_t                    result
);

	logic [icv_pkg::ADDR_W-1:0]   slot_base_q;
	logic [icv_pkg::SIZE_W-1:0]   slot_size_q;
	logic [icv_pkg::OFFSET_W-1:0] crc_offset_q;
	logic [icv_pkg::ADDR_W-1:0]   ram_end_q;
	logic [31:0]                  expected_crc_q;

	logic                         valid_s1;
	icv_pkg::byte_req_t           req_s1;

	logic [31:0]                  crc_q;
	logic [icv_pkg::POS_W-1:0]    pos_q;
	logic [31:0]                  sp_q;
	logic [31:0]                  rv_q;
	logic                         exceeded_q;

	logic                         res_valid_q;
	icv_pkg::result_t             res_q;

	logic                         go_s1;
	logic                         at_max;
	logic [icv_pkg::POS_W-1:0]    offset_ext;
	logic                         in_field;
	logic [7:0]                   crc_in;
	logic [31:0]                  crc_nx;
	logic [icv_pkg::POS_W-1:0]    pos_nx;
	logic                         exceeded_nx;
	logic [31:0]                  sp_nx;
	logic [31:0]                  rv_nx;
	logic [31:0]                  rv_even;
	logic [icv_pkg::ADDR_W:0]     slot_end;
	logic                         enough;
	logic                         sp_ok;
	logic                         rv_ok;
	icv_pkg::result_t             res_nx;

	assign byte_stall = valid_s1 && req_s1.last_byte && res_valid_q && result_stall;
	assign go_s1 = valid_s1 && !byte_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_base_q    <= icv_pkg::RST_SLOT_BASE;
			slot_size_q    <= icv_pkg::RST_SLOT_SIZE;
			crc_offset_q   <= icv_pkg::RST_CRC_OFFSET;
			ram_end_q      <= icv_pkg::RST_RAM_END;
			expected_crc_q <= icv_pkg::RST_EXPECTED_CRC;
		end else if (wr_en) begin
			unique case (wr_index)
				icv_pkg::REG_SLOT_BASE: begin
					slot_base_q <= wr_data;
				end
				icv_pkg::REG_SLOT_SIZE: begin
					slot_size_q <= wr_data[icv_pkg::SIZE_W-1:0];
				end
				icv_pkg::REG_CRC_OFFSET: begin
					crc_offset_q <= wr_data[icv_pkg::OFFSET_W-1:0];
				end
				icv_pkg::REG_RAM_END: begin
					ram_end_q <= wr_data;
				end
				icv_pkg::REG_EXPECTED_CRC: begin
					expected_crc_q <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			req_s1 <= byte_req;
		end
	end

	// per-byte update
	always_comb begin
		at_max      = (pos_q == icv_pkg::POS_MAX);
		offset_ext  = icv_pkg::POS_W'(crc_offset_q);
		in_field    = (pos_q >= offset_ext) && ((pos_q - offset_ext) < icv_pkg::FIELD_BYTES);
		crc_in      = (in_field && !at_max) ? 8'd0 : req_s1.data_byte;
		crc_nx      = icv_pkg::crc_byte(crc_q, crc_in);
		pos_nx      = at_max ? pos_q : pos_q + 1'b1;
		exceeded_nx = exceeded_q || at_max;
		sp_nx       = sp_q;
		rv_nx       = rv_q;
		if (!at_max && pos_q < icv_pkg::VECTOR_BYTES) begin
			unique case (pos_q[2:0])
				3'd0: sp_nx[7:0]   = req_s1.data_byte;
				3'd1: sp_nx[15:8]  = req_s1.data_byte;
				3'd2: sp_nx[23:16] = req_s1.data_byte;
				3'd3: sp_nx[31:24] = req_s1.data_byte;
				3'd4: rv_nx[7:0]   = req_s1.data_byte;
				3'd5: rv_nx[15:8]  = req_s1.data_byte;
				3'd6: rv_nx[23:16] = req_s1.data_byte;
				default: rv_nx[31:24] = req_s1.data_byte;
			endcase
		end

		rv_even  = {rv_nx[31:1], 1'b0};
		slot_end = {1'b0, slot_base_q} + (icv_pkg::ADDR_W + 1)'(slot_size_q);
		enough   = exceeded_nx || (pos_nx >= icv_pkg::VECTOR_BYTES);
		sp_ok    = (sp_nx >= icv_pkg::RAM_BASE) && (sp_nx <= ram_end_q);
		rv_ok    = (rv_even >= slot_base_q) && ({1'b0, rv_even} < slot_end);

		res_nx.crc_value = ~crc_nx;
		res_nx.crc_match = (~crc_nx == expected_crc_q);
		res_nx.vector_ok = enough && sp_ok && rv_ok;
		res_nx.size_ok   = !exceeded_nx && (icv_pkg::SIZE_W'(pos_nx) <= slot_size_q);
	end

	// image state, cleared after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= icv_pkg::CRC_INIT;
			pos_q      <= '0;
			sp_q       <= '0;
			rv_q       <= '0;
			exceeded_q <= 1'b0;
		end else if (go_s1) begin
			if (req_s1.last_byte) begin
				crc_q      <= icv_pkg::CRC_INIT;
				pos_q      <= '0;
				sp_q       <= '0;
				rv_q       <= '0;
				exceeded_q <= 1'b0;
			end else begin
				crc_q      <= crc_nx;
				pos_q      <= pos_nx;
				sp_q       <= sp_nx;
				rv_q       <= rv_nx;
				exceeded_q <= exceeded_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go_s1 && req_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && req_s1.last_byte) begin
			res_q <= res_nx;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

@@ design/icv_checker.sv @@
// Port-level checks for the image verifier, bound to the top level.
// Depends on icv_pkg and image_crc32_vector_verifier_assert.svh.
`timescale 1ns / 1ps
`include "image_crc32_vector_verifier_assert.svh"

module icv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               byte_valid,
	input logic               byte_stall,
	input icv_pkg::byte_req_t byte_req,
	input logic               result_valid,
	input logic               result_stall,
	input icv_pkg::result_t   result
);

	`ICV_ASSERT(a_result_held, result_valid && result_stall |=> result_valid)
	`ICV_ASSERT(a_result_stable, result_valid && result_stall |=> $stable(result))
	// a fresh result comes from a last byte taken earlier at the byte input
	`ICV_ASSERT(a_result_source, $rose(result_valid) |-> $past(byte_valid && !byte_stall && byte_req.last_byte, 2))
	// the byte side only backs up behind a stalled result
	`ICV_ASSERT_ALWAYS(a_stall_cause, byte_stall |-> result_valid && result_stall)

endmodule

bind image_crc32_vector_verifier icv_checker u_icv_checker (.*);
